/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/ddo_pkg.sv */
// Shared types, constants and the arctangent table function of the odometry block.
package ddo_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int ADDR_W = 4;

   // Configuration reset values
   localparam logic [15:0] SCALE_RST = 16'd32639;
   localparam logic [31:0] MM_RST    = 32'd424257;
   localparam logic [31:0] RAD_RST   = 32'd324984;

   // Angle constants
   localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629713;
   localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [33:0] PI_Q27      = 34'sd421657428;
   localparam logic signed [33:0] TWO_PI_Q27  = 34'sd843314857;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   typedef enum logic [1:0] {
      REG_SCALE = 2'd0,
      REG_MM    = 2'd1,
      REG_RAD   = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SL, OP_SUMS, OP_MUL_LO, OP_MUL_HI, OP_ADD, OP_ROUND,
      OP_ANGLE, OP_MOD, OP_WRAP, OP_FOLD, OP_CORDIC, OP_MULX, OP_ACCX, OP_ACCY
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SL, ST_SUMS, ST_LO, ST_HI, ST_ADD, ST_RND, ST_ANGLE, ST_MOD,
      ST_WRAP, ST_FOLD, ST_CORDIC, ST_MULX, ST_ACCX, ST_ACCY
   } state_type;

   typedef struct packed {
      op_type op;
      logic   sel_ang;   // second pass of the scale unit: angular step
   } cmd_type;

   typedef struct packed {
      logic mod_ok;
      logic cordic_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [15:0] scale;
      logic [31:0] mm;
      logic [31:0] rad;
   } cfg_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] linear_step;
      logic signed [31:0] angular_step;
      logic signed [15:0] right_total;
      logic signed [15:0] left_total;
   } result_type;

   // floor(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0: val = 30'd843314856;
         5'd1: val = 30'd497837829;
         5'd2: val = 30'd263043836;
         5'd3: val = 30'd133525158;
         5'd4: val = 30'd67021686;
         5'd5: val = 30'd33543515;
         5'd6: val = 30'd16775850;
         5'd7: val = 30'd8388437;
         5'd8: val = 30'd4194282;
         5'd9: val = 30'd2097149;
         5'd31: val = 30'd0;
         default: val = (30'd1 << (5'd30 - idx)) - 30'd1;
      endcase
      return val;
   endfunction

endpackage

/* rtl/ddo_ifs.sv */
// Valid/ready channel interfaces for encoder ticks and odometry results.
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] right_delta;
   logic signed [15:0] left_delta;
   modport source (output valid, right_delta, left_delta, input ready);
   modport sink (input valid, right_delta, left_delta, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] pos_x;
   logic signed [47:0] pos_y;
   logic signed [31:0] heading;
   logic signed [31:0] linear_step;
   logic signed [31:0] angular_step;
   logic signed [15:0] right_total;
   logic signed [15:0] left_total;
   modport source (output valid, pos_x, pos_y, heading, linear_step, angular_step,
                   right_total, left_total, input ready);
   modport sink (input valid, pos_x, pos_y, heading, linear_step, angular_step,
                 right_total, left_total, output ready);
endinterface

/* rtl/ddo_csr.sv */
// APB register file holding the wheel scale and per-count factors.
module ddo_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output ddo_pkg::cfg_type            cfg
);

   logic [15:0] scale_ff, scale_in;
   logic [31:0] mm_ff, mm_in;
   logic [31:0] rad_ff, rad_in;
   logic        wr_en;
   ddo_pkg::reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = ddo_pkg::reg_index_type'(paddr[3:2]);

   // Register write decode
   always_comb begin
      scale_in = scale_ff;
      mm_in    = mm_ff;
      rad_in   = rad_ff;
      if (wr_en) begin
         case (idx)
            ddo_pkg::REG_SCALE: scale_in = pwdata[15:0];
            ddo_pkg::REG_MM:    mm_in    = pwdata;
            ddo_pkg::REG_RAD:   rad_in   = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ddo_pkg::SCALE_RST;
         mm_ff    <= ddo_pkg::MM_RST;
         rad_ff   <= ddo_pkg::RAD_RST;
      end else begin
         scale_ff <= scale_in;
         mm_ff    <= mm_in;
         rad_ff   <= rad_in;
      end
   end

   // Read mux
   always_comb begin
      case (idx)
         ddo_pkg::REG_SCALE: prdata = {16'd0, scale_ff};
         ddo_pkg::REG_MM:    prdata = mm_ff;
         ddo_pkg::REG_RAD:   prdata = rad_ff;
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg = '{scale: scale_ff, mm: mm_ff, rad: rad_ff};

endmodule

/* rtl/ddo_ctrl.sv */
// Sequencer that walks one encoder tick through the datapath steps.
module ddo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ddo_pkg::status_type   status,
   output ddo_pkg::cmd_type      cmd
);

   ddo_pkg::state_type state_ff, state_in;
   logic               sel_ff, sel_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ddo_pkg::ST_SL;
               sel_in   = 1'b0;
            end
         end
         ddo_pkg::ST_SL:    state_in = ddo_pkg::ST_SUMS;
         ddo_pkg::ST_SUMS:  state_in = ddo_pkg::ST_LO;
         ddo_pkg::ST_LO:    state_in = ddo_pkg::ST_HI;
         ddo_pkg::ST_HI:    state_in = ddo_pkg::ST_ADD;
         ddo_pkg::ST_ADD:   state_in = ddo_pkg::ST_RND;
         ddo_pkg::ST_RND: begin
            if (sel_ff) begin
               state_in = ddo_pkg::ST_ANGLE;
            end else begin
               state_in = ddo_pkg::ST_LO;
               sel_in   = 1'b1;
            end
         end
         ddo_pkg::ST_ANGLE: state_in = ddo_pkg::ST_MOD;
         ddo_pkg::ST_MOD: begin
            if (status.mod_ok) state_in = ddo_pkg::ST_WRAP;
         end
         ddo_pkg::ST_WRAP:  state_in = ddo_pkg::ST_FOLD;
         ddo_pkg::ST_FOLD:  state_in = ddo_pkg::ST_CORDIC;
         ddo_pkg::ST_CORDIC: begin
            if (status.cordic_last) state_in = ddo_pkg::ST_MULX;
         end
         ddo_pkg::ST_MULX:  state_in = ddo_pkg::ST_ACCX;
         ddo_pkg::ST_ACCX:  state_in = ddo_pkg::ST_ACCY;
         ddo_pkg::ST_ACCY: begin
            if (status.out_free) state_in = ddo_pkg::ST_IDLE;
         end
         default: state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.sel_ang = sel_ff;
      req_ready   = 1'b0;
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? ddo_pkg::OP_LOAD : ddo_pkg::OP_NONE;
         end
         ddo_pkg::ST_SL:     cmd.op = ddo_pkg::OP_SL;
         ddo_pkg::ST_SUMS:   cmd.op = ddo_pkg::OP_SUMS;
         ddo_pkg::ST_LO:     cmd.op = ddo_pkg::OP_MUL_LO;
         ddo_pkg::ST_HI:     cmd.op = ddo_pkg::OP_MUL_HI;
         ddo_pkg::ST_ADD:    cmd.op = ddo_pkg::OP_ADD;
         ddo_pkg::ST_RND:    cmd.op = ddo_pkg::OP_ROUND;
         ddo_pkg::ST_ANGLE:  cmd.op = ddo_pkg::OP_ANGLE;
         ddo_pkg::ST_MOD:    cmd.op = ddo_pkg::OP_MOD;
         ddo_pkg::ST_WRAP:   cmd.op = ddo_pkg::OP_WRAP;
         ddo_pkg::ST_FOLD:   cmd.op = ddo_pkg::OP_FOLD;
         ddo_pkg::ST_CORDIC: cmd.op = ddo_pkg::OP_CORDIC;
         ddo_pkg::ST_MULX:   cmd.op = ddo_pkg::OP_MULX;
         ddo_pkg::ST_ACCX:   cmd.op = ddo_pkg::OP_ACCX;
         ddo_pkg::ST_ACCY:
            cmd.op = status.out_free ? ddo_pkg::OP_ACCY : ddo_pkg::OP_NONE;
         default:            cmd.op = ddo_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

/* rtl/ddo_dp.sv */
// Odometry datapath: step scaling, angle reduction, CORDIC and accumulators.
module ddo_dp #(
   parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ddo_pkg::cmd_type      cmd,
   output ddo_pkg::status_type   status,
   input  ddo_pkg::cfg_type      cfg,
   input  logic signed [15:0]    req_right,
   input  logic signed [15:0]    req_left,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ddo_pkg::result_type   rsp_data
);

   localparam int IW = $clog2(CORDIC_STAGES);

   // Input latch and scale unit
   logic signed [15:0] r_ff, r_in, l_ff, l_in;
   logic [48:0]        prod_ff, prod_in;
   logic [64:0]        acc_ff, acc_in;
   logic [32:0]        mag_s_ff, mag_s_in, mag_t_ff, mag_t_in;
   logic               s_neg_ff, s_neg_in, t_neg_ff, t_neg_in;
   logic [15:0]        ltr_ff, ltr_in;
   logic signed [31:0] lin_ff, lin_in, ang_ff, ang_in;
   // Angle and CORDIC
   logic signed [35:0] v_ff, v_in, z_ff, z_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic [IW-1:0]      i_ff, i_in;
   logic               flip_ff, flip_in;
   logic signed [63:0] pprod_ff, pprod_in;
   // Architectural state
   logic signed [47:0] x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [31:0] theta_ff, theta_in;
   logic [15:0]        rsum_ff, rsum_in, lsum_ff, lsum_in;
   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   ddo_pkg::result_type out_ff, out_in;

   // Shared unsigned multiplier
   logic [32:0] mul_a;
   logic [15:0] mul_b, labs;
   logic [31:0] fsel;
   logic [48:0] mul_p;
   // Position multiplier
   logic signed [33:0] xs, ys;
   logic signed [31:0] pm_b;
   logic signed [63:0] pm_p;

   logic signed [33:0] sl, r15, s_sum, t_sum;
   logic [15:0]        lq;
   logic [64:0]        rnd, shv;
   logic               rneg;
   logic signed [31:0] rres;
   logic signed [33:0] dx, dy;
   logic signed [35:0] atan_v, zf;
   logic signed [63:0] pround;
   logic signed [48:0] new_pos;
   logic signed [33:0] th;

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] res;
      if (v[48] != v[47]) res = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else res = v[47:0];
      return res;
   endfunction

   // Multiplier operand selection
   assign labs  = l_ff[15] ? 16'(-l_ff) : 16'(l_ff);
   assign fsel  = cmd.sel_ang ? cfg.rad : cfg.mm;
   assign mul_a = (cmd.op == ddo_pkg::OP_SL) ? {17'd0, labs}
                : (cmd.sel_ang ? mag_t_ff : mag_s_ff);
   assign mul_b = (cmd.op == ddo_pkg::OP_SL) ? cfg.scale
                : ((cmd.op == ddo_pkg::OP_MUL_HI) ? fsel[31:16] : fsel[15:0]);
   assign mul_p = mul_a * mul_b;

   assign xs   = flip_ff ? -x_ff : x_ff;
   assign ys   = flip_ff ? -y_ff : y_ff;
   assign pm_b = (cmd.op == ddo_pkg::OP_MULX) ? xs[31:0] : ys[31:0];
   assign pm_p = lin_ff * pm_b;

   // Signed sum and difference of the wheels, Q.15 counts
   assign sl    = l_ff[15] ? -$signed({2'b00, prod_ff[31:0]})
                           : $signed({2'b00, prod_ff[31:0]});
   assign r15   = $signed({{3{r_ff[15]}}, r_ff, 15'd0});
   assign s_sum = r15 + sl;
   assign t_sum = r15 - sl;
   assign lq    = prod_ff[30:15];

   // Round on magnitude and saturate
   assign rnd  = acc_ff + (cmd.sel_ang ? (65'd1 << 19) : (65'd1 << 23));
   assign shv  = cmd.sel_ang ? (rnd >> 20) : (rnd >> 24);
   assign rneg = cmd.sel_ang ? t_neg_ff : s_neg_ff;
   always_comb begin
      if (rneg) rres = (shv > 65'h80000000) ? 32'sh80000000 : -$signed(shv[31:0]);
      else rres = (shv > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(shv[31:0]);
   end

   // CORDIC micro-rotation
   assign dx     = y_ff >>> i_ff;
   assign dy     = x_ff >>> i_ff;
   assign atan_v = $signed({6'd0, ddo_pkg::atan_entry(5'(i_ff))});
   assign zf     = $signed({v_ff[33:0], 2'b00});

   assign pround = pprod_ff + 64'sd536870912;

   always_comb begin
      r_in = r_ff;  l_in = l_ff;  prod_in = prod_ff;  acc_in = acc_ff;
      mag_s_in = mag_s_ff;  mag_t_in = mag_t_ff;
      s_neg_in = s_neg_ff;  t_neg_in = t_neg_ff;  ltr_in = ltr_ff;
      lin_in = lin_ff;  ang_in = ang_ff;  v_in = v_ff;  z_in = z_ff;
      x_in = x_ff;  y_in = y_ff;  i_in = i_ff;  flip_in = flip_ff;
      pprod_in = pprod_ff;  x_acc_in = x_acc_ff;  y_acc_in = y_acc_ff;
      theta_in = theta_ff;  rsum_in = rsum_ff;  lsum_in = lsum_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      new_pos = 49'sd0;
      th = 34'sd0;
      case (cmd.op)
         ddo_pkg::OP_LOAD: begin
            r_in = req_right;
            l_in = req_left;
         end
         ddo_pkg::OP_SL: prod_in = mul_p;
         ddo_pkg::OP_SUMS: begin
            s_neg_in = s_sum[33];
            t_neg_in = t_sum[33];
            mag_s_in = s_sum[33] ? 33'(-s_sum) : 33'(s_sum);
            mag_t_in = t_sum[33] ? 33'(-t_sum) : 33'(t_sum);
            ltr_in   = l_ff[15] ? 16'(-lq) : lq;
         end
         ddo_pkg::OP_MUL_LO: prod_in = mul_p;
         ddo_pkg::OP_MUL_HI: begin
            acc_in  = {16'd0, prod_ff};
            prod_in = mul_p;
         end
         ddo_pkg::OP_ADD: acc_in = acc_ff + {prod_ff, 16'd0};
         ddo_pkg::OP_ROUND: begin
            if (cmd.sel_ang) ang_in = rres;
            else lin_in = rres;
         end
         ddo_pkg::OP_ANGLE: v_in = 36'(theta_ff) * 36'sd2 + 36'(ang_ff);
         ddo_pkg::OP_MOD: begin
            // one step of the modulo into [0, 2*pi)
            if (v_ff < 36'sd0) v_in = v_ff + ddo_pkg::TWO_PI_Q28;
            else if (v_ff >= ddo_pkg::TWO_PI_Q28) v_in = v_ff - ddo_pkg::TWO_PI_Q28;
         end
         ddo_pkg::OP_WRAP: begin
            if (v_ff > ddo_pkg::PI_Q28) v_in = v_ff - ddo_pkg::TWO_PI_Q28;
         end
         ddo_pkg::OP_FOLD: begin
            // fold into the right half plane; cos and sin change sign
            x_in = ddo_pkg::GAIN_Q30;
            y_in = 34'sd0;
            i_in = '0;
            if (zf > ddo_pkg::HALF_PI_Q30) begin
               z_in = zf - ddo_pkg::PI_Q30;
               flip_in = 1'b1;
            end else if (zf < -ddo_pkg::HALF_PI_Q30) begin
               z_in = zf + ddo_pkg::PI_Q30;
               flip_in = 1'b1;
            end else begin
               z_in = zf;
               flip_in = 1'b0;
            end
         end
         ddo_pkg::OP_CORDIC: begin
            if (!z_ff[35]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_v;
            end
            i_in = i_ff + 1'b1;
         end
         ddo_pkg::OP_MULX: pprod_in = pm_p;
         ddo_pkg::OP_ACCX: begin
            new_pos  = 49'(x_acc_ff) + 49'($signed(pround[63:30]));
            x_acc_in = sat48(new_pos);
            pprod_in = pm_p;
         end
         ddo_pkg::OP_ACCY: begin
            new_pos  = 49'(y_acc_ff) + 49'($signed(pround[63:30]));
            y_acc_in = sat48(new_pos);
            // heading: add, wrap once, saturate
            th = 34'(theta_ff) + 34'(ang_ff);
            if (th > ddo_pkg::PI_Q27) th = th - ddo_pkg::TWO_PI_Q27;
            else if (th < -ddo_pkg::PI_Q27) th = th + ddo_pkg::TWO_PI_Q27;
            if (th > 34'sd2147483647) theta_in = 32'sh7FFFFFFF;
            else if (th < -34'sd2147483648) theta_in = 32'sh80000000;
            else theta_in = th[31:0];
            rsum_in = rsum_ff + r_ff;
            lsum_in = lsum_ff + ltr_ff;
            out_in.pos_x        = x_acc_ff;
            out_in.pos_y        = sat48(new_pos);
            out_in.heading      = theta_in;
            out_in.linear_step  = lin_ff;
            out_in.angular_step = ang_ff;
            out_in.right_total  = rsum_in;
            out_in.left_total   = lsum_in;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      r_ff <= r_in;  l_ff <= l_in;  prod_ff <= prod_in;  acc_ff <= acc_in;
      mag_s_ff <= mag_s_in;  mag_t_ff <= mag_t_in;
      s_neg_ff <= s_neg_in;  t_neg_ff <= t_neg_in;  ltr_ff <= ltr_in;
      lin_ff <= lin_in;  ang_ff <= ang_in;  v_ff <= v_in;  z_ff <= z_in;
      x_ff <= x_in;  y_ff <= y_in;  i_ff <= i_in;  flip_ff <= flip_in;
      pprod_ff <= pprod_in;  out_ff <= out_in;
   end

   // Odometry state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         theta_ff     <= '0;
         rsum_ff      <= '0;
         lsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         theta_ff     <= theta_in;
         rsum_ff      <= rsum_in;
         lsum_ff      <= lsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.mod_ok      = !v_ff[35] && (v_ff < ddo_pkg::TWO_PI_Q28);
   assign status.cordic_last = (i_ff == IW'(CORDIC_STAGES - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = out_ff;

endmodule

/* rtl/differential_drive_odometry_top.sv */
// Top level of the differential-drive odometry block.
//
//  channel   role     handshake           payload
//  req_chan  input    valid/ready         right_delta, left_delta (s16)
//  rsp_chan  output   valid/ready         pos_x, pos_y, heading, steps, totals
//  csr (APB) config   psel/penable/pready scale, mm/count, rad/count
//
// A tick passes through scaling of the wheel steps, modulo-2pi angle reduction,
// the CORDIC iterations and the position and heading updates before a result.
// One tick is in flight at a time; the next is taken once the result sits
// in the output register. A stalled result holds the sequencer in its last step.
// Reset is synchronous and clears position, heading, totals and output valid;
// the configuration registers return to their reset values.
module differential_drive_odometry_top #(
   parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   ddo_req_if.sink                     req_chan,
   ddo_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   ddo_pkg::cfg_type    cfg;
   ddo_pkg::cmd_type    cmd;
   ddo_pkg::status_type status;
   ddo_pkg::result_type result;
   logic                req_ready;
   logic                rsp_valid;

   ddo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddo_dp #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg),
      .req_right (req_chan.right_delta),
      .req_left  (req_chan.left_delta),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (result)
   );

   // Channel hookup
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.pos_x        = result.pos_x;
   assign rsp_chan.pos_y        = result.pos_y;
   assign rsp_chan.heading      = result.heading;
   assign rsp_chan.linear_step  = result.linear_step;
   assign rsp_chan.angular_step = result.angular_step;
   assign rsp_chan.right_total  = result.right_total;
   assign rsp_chan.left_total   = result.left_total;

endmodule

/* rtl/ddo_check.sv */
// Port-level checker for the odometry block, bound to the top level.
`include "assert_macros.svh"

module ddo_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a pending result waits for the consumer
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // reset empties the output register
   `ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)
   // one tick at a time: busy right after a transaction
   `ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a result never appears the cycle after a transaction
   `ASSERT_NEXT(a_no_fast_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

endmodule

bind differential_drive_odometry_top ddo_check u_ddo_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
